>>> hdl/udp_command_frame_classifier_defines.svh
// Assertion macros for the UDP command frame classifier.
// Included by files that check their own logic; no other dependencies.
`ifndef UDP_COMMAND_FRAME_CLASSIFIER_DEFINES_SVH
`define UDP_COMMAND_FRAME_CLASSIFIER_DEFINES_SVH

`ifndef ASSERT_OFF
`define UCFC_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ucfc same-cycle check failed");
`define UCFC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ucfc next-cycle check failed");
`else
`define UCFC_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define UCFC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

>>> hdl/ucfc_pkg.sv
// Shared widths, header offsets and result codes for the frame classifier.
// No dependencies.
package ucfc_pkg;

  localparam int NUM_DRIVES = 4;
  localparam int POS_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  localparam logic [POS_W-1:0] MAX_FRAME = 11'd2047;
  localparam logic [POS_W-1:0] HDR_LEN   = 11'd42;
  localparam logic [15:0]      UDP_HDR_LEN = 16'd8;

  localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_IP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CMD_PORT = 2'd2;

  localparam logic [47:0] OWN_MAC_RST  = 48'd181366822011136;
  localparam logic [31:0] OWN_IP_RST   = 32'd174285667;
  localparam logic [15:0] CMD_PORT_RST = 16'd11333;

  localparam logic [2:0] V_ADDR_MISS = 3'd0;
  localparam logic [2:0] V_NOT_UDP   = 3'd1;
  localparam logic [2:0] V_LEN_ERR   = 3'd2;
  localparam logic [2:0] V_UNHANDLED = 3'd3;
  localparam logic [2:0] V_STATUS    = 3'd4;
  localparam logic [2:0] V_MODES     = 3'd5;
  localparam logic [2:0] V_TARGETS   = 3'd6;

  localparam logic [1:0] CLS_NONE  = 2'd0;
  localparam logic [1:0] CLS_UCAST = 2'd1;
  localparam logic [1:0] CLS_MCAST = 2'd2;
  localparam logic [1:0] CLS_BCAST = 2'd3;

  localparam logic [7:0] CMD_STATUS  = 8'd0;
  localparam logic [7:0] CMD_MODES   = 8'd1;
  localparam logic [7:0] CMD_TARGETS = 8'd2;

endpackage

>>> hdl/ucfc_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on ucfc_pkg for widths.
interface ucfc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ucfc_pkg::CFG_IDX_W-1:0]  index;
  logic [ucfc_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/ucfc_in_if.sv
// Frame byte channel: one frame byte per beat, last_byte marks the end.
// No dependencies.
interface ucfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;
  modport source (output valid, frame_byte, last_byte, input ready);
  modport sink (input valid, frame_byte, last_byte, output ready);
endinterface

>>> hdl/ucfc_out_if.sv
// Result channel: one verdict beat per frame with decoded command fields.
// No dependencies.
interface ucfc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  verdict;
  logic [1:0]  address_class;
  logic        handled;
  logic [7:0]  mode_0;
  logic [7:0]  mode_1;
  logic [7:0]  mode_2;
  logic [7:0]  mode_3;
  logic [15:0] target_0;
  logic [15:0] target_1;
  logic [15:0] target_2;
  logic [15:0] target_3;
  modport source (output valid, verdict, address_class, handled, mode_0, mode_1, mode_2,
                  mode_3, target_0, target_1, target_2, target_3, input ready);
  modport sink (input valid, verdict, address_class, handled, mode_0, mode_1, mode_2,
                mode_3, target_0, target_1, target_2, target_3, output ready);
endinterface

>>> hdl/udp_command_frame_classifier.sv
// UDP command frame classifier: one frame byte per beat, one result per frame.
// The last_byte beat is held in the input register, then its result in the result register.
// Throughput: one byte per cycle; the input register and the frame state update run
// every cycle, stalling only when a last byte meets a result waiting in the output register.
// Reset (rst, synchronous): clears frame state and both pipeline valids, loads the
// default MAC, IP and command port. Depends on ucfc_pkg, the interfaces, the defines.
`include "udp_command_frame_classifier_defines.svh"

module udp_command_frame_classifier (
  input logic       clk,
  input logic       rst,
  ucfc_cfg_if.sink  cfg,
  ucfc_in_if.sink   frame,
  ucfc_out_if.source result
);
  import ucfc_pkg::*;

  localparam logic [15:0] MODE_MIN   = 16'(1 + NUM_DRIVES);
  localparam logic [15:0] TARGET_MIN = 16'(1 + 2 * NUM_DRIVES);

  logic [47:0] own_mac;
  logic [31:0] own_ip;
  logic [15:0] command_port;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_move;

  logic [POS_W-1:0] byte_position, pos_next;
  logic [2:0]       match_flags, flags_next;
  logic             header_ok, hdr_next;
  logic             ip_check_needed, ipchk_next;
  logic [15:0]      dest_port_seen, dport_next;
  logic [15:0]      udp_length_seen, ulen_next;
  logic [7:0]       command_byte, cmd_next;
  logic [7:0]       payload_bytes [8];
  logic [7:0]       pay_next [8];

  logic [7:0]       mac_byte, ip_byte;
  logic [1:0]       ip_off;
  logic [POS_W-1:0] pay_idx;
  logic [15:0]      plen, room;
  logic [2:0]       verdict_next;
  logic [1:0]       cls_next;
  logic [7:0]       mode_next [4];
  logic [15:0]      target_next [4];

  logic        out_valid;
  logic [2:0]  verdict;
  logic [1:0]  address_class;
  logic [7:0]  mode_q [4];
  logic [15:0] target_q [4];

  assign cfg.ready   = 1'b1;
  assign s1_move     = s1_valid && (!s1_last || !out_valid || result.ready);
  assign frame.ready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac      <= OWN_MAC_RST;
      own_ip       <= OWN_IP_RST;
      command_port <= CMD_PORT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_OWN_MAC:  own_mac      <= cfg.data;
        REG_OWN_IP:   own_ip       <= cfg.data[31:0];
        REG_CMD_PORT: command_port <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (frame.ready) begin
      s1_valid <= frame.valid;
    end
    if (frame.valid && frame.ready) begin
      s1_byte <= frame.frame_byte;
      s1_last <= frame.last_byte;
    end
  end

  // per-byte header parsing
  always_comb begin
    mac_byte   = 8'(own_mac >> {3'd5 - byte_position[2:0], 3'b000});
    ip_off     = 2'(byte_position - 11'd30);
    ip_byte    = 8'(own_ip >> {2'd3 - ip_off, 3'b000});
    pay_idx    = byte_position - 11'd43;
    pos_next   = byte_position;
    flags_next = match_flags;
    hdr_next   = header_ok;
    ipchk_next = ip_check_needed;
    dport_next = dest_port_seen;
    ulen_next  = udp_length_seen;
    cmd_next   = command_byte;
    for (int i = 0; i < 8; i++) begin
      pay_next[i] = payload_bytes[i];
    end
    if (byte_position < MAX_FRAME) begin
      pos_next = byte_position + 11'd1;
      if (byte_position < 11'd6) begin
        if (s1_byte != mac_byte) flags_next[0] = 1'b0;
        if (s1_byte != 8'hff) flags_next[2] = 1'b0;
        if ((byte_position == 11'd0 && s1_byte != 8'h01) ||
            (byte_position == 11'd1 && s1_byte != 8'h00) ||
            (byte_position == 11'd2 && s1_byte != 8'h5e)) begin
          flags_next[1] = 1'b0;
        end
        if (byte_position == 11'd0 && s1_byte == mac_byte) ipchk_next = 1'b1;
      end else if (byte_position == 11'd12) begin
        if (s1_byte != 8'h08) hdr_next = 1'b0;
      end else if (byte_position == 11'd13) begin
        if (s1_byte != 8'h00) hdr_next = 1'b0;
      end else if (byte_position == 11'd14) begin
        if (s1_byte[7:4] != 4'd4) hdr_next = 1'b0;
      end else if (byte_position == 11'd23) begin
        if (s1_byte != 8'h11) hdr_next = 1'b0;
      end else if (byte_position >= 11'd30 && byte_position <= 11'd33) begin
        if (ip_check_needed && s1_byte != ip_byte) hdr_next = 1'b0;
      end else if (byte_position == 11'd36 || byte_position == 11'd37) begin
        dport_next = {dest_port_seen[7:0], s1_byte};
      end else if (byte_position == 11'd38 || byte_position == 11'd39) begin
        ulen_next = {udp_length_seen[7:0], s1_byte};
      end else if (byte_position == 11'd42) begin
        cmd_next = s1_byte;
      end else if (byte_position >= 11'd43 && byte_position <= 11'd50) begin
        pay_next[pay_idx[2:0]] = s1_byte;
      end
    end
  end

  // frame verdict from the state after this byte
  always_comb begin
    plen         = ulen_next - UDP_HDR_LEN;
    room         = {5'd0, pos_next - HDR_LEN};
    verdict_next = V_UNHANDLED;
    cls_next     = CLS_UCAST;
    if (pos_next < 11'd6 || flags_next == 3'd0) begin
      verdict_next = V_ADDR_MISS;
      cls_next     = CLS_NONE;
    end else begin
      if (flags_next[2]) begin
        cls_next = CLS_BCAST;
      end else if (flags_next[1]) begin
        cls_next = CLS_MCAST;
      end
      if (pos_next < HDR_LEN) begin
        verdict_next = V_LEN_ERR;
      end else if (!hdr_next) begin
        verdict_next = V_NOT_UDP;
      end else if (ulen_next < UDP_HDR_LEN || plen > room) begin
        verdict_next = V_LEN_ERR;
      end else if (dport_next == command_port && plen != 16'd0) begin
        if (cmd_next == CMD_STATUS) begin
          verdict_next = V_STATUS;
        end else if (cmd_next == CMD_MODES && plen >= MODE_MIN) begin
          verdict_next = V_MODES;
        end else if (cmd_next == CMD_TARGETS && plen >= TARGET_MIN) begin
          verdict_next = V_TARGETS;
        end
      end
    end
    for (int i = 0; i < 4; i++) begin
      mode_next[i]   = 8'd0;
      target_next[i] = 16'd0;
      if (i < NUM_DRIVES && verdict_next == V_MODES) mode_next[i] = pay_next[i];
      if (i < NUM_DRIVES && verdict_next == V_TARGETS) begin
        target_next[i] = {pay_next[2*i], pay_next[2*i+1]};
      end
    end
  end

  // frame state: advance per byte, clear at frame end
  always_ff @(posedge clk) begin
    if (rst || (s1_move && s1_last)) begin
      byte_position   <= '0;
      match_flags     <= 3'b111;
      header_ok       <= 1'b1;
      ip_check_needed <= 1'b0;
      dest_port_seen  <= '0;
      udp_length_seen <= '0;
      command_byte    <= '0;
      for (int i = 0; i < 8; i++) begin
        payload_bytes[i] <= '0;
      end
    end else if (s1_move) begin
      byte_position   <= pos_next;
      match_flags     <= flags_next;
      header_ok       <= hdr_next;
      ip_check_needed <= ipchk_next;
      dest_port_seen  <= dport_next;
      udp_length_seen <= ulen_next;
      command_byte    <= cmd_next;
      for (int i = 0; i < 8; i++) begin
        payload_bytes[i] <= pay_next[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move && s1_last) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_move && s1_last) begin
      verdict       <= verdict_next;
      address_class <= cls_next;
      mode_q        <= mode_next;
      target_q      <= target_next;
    end
  end

  assign result.valid         = out_valid;
  assign result.verdict       = verdict;
  assign result.address_class = address_class;
  assign result.handled       = (verdict == V_MODES) || (verdict == V_TARGETS);
  assign result.mode_0        = mode_q[0];
  assign result.mode_1        = mode_q[1];
  assign result.mode_2        = mode_q[2];
  assign result.mode_3        = mode_q[3];
  assign result.target_0      = target_q[0];
  assign result.target_1      = target_q[1];
  assign result.target_2      = target_q[2];
  assign result.target_3      = target_q[3];

  `UCFC_ASSERT_NEXT(a_last_gives_result, clk, rst, s1_move && s1_last, out_valid)
  `UCFC_ASSERT_NEXT(a_frame_state_clears, clk, rst, s1_move && s1_last,
                    byte_position == '0 && match_flags == 3'b111)
  `UCFC_ASSERT_IMPLY(a_miss_has_no_class, clk, rst, out_valid && verdict == V_ADDR_MISS,
                     address_class == CLS_NONE)
  `UCFC_ASSERT_IMPLY(a_no_stall_on_mid_frame, clk, rst, s1_valid && !s1_last, s1_move)

endmodule
